>>> hw/rtl/izh_pkg.sv
package izh_pkg;

	// Fixed-point format and model constants (signed Q16.16).
	localparam int Q_FRAC = 16;
	localparam int ADDR_W = 5;
	localparam int MUL_W  = 33;
	localparam int PROD_W = 2 * MUL_W;

	localparam logic signed [12:0] K_QUAD = 13'sd2621;
	localparam logic signed [31:0] K_REST = 32'sd9175040;
	localparam logic signed [31:0] V_INIT = -32'sd4587520;
	localparam logic signed [31:0] U_INIT = -32'sd917504;

	// Register reset values.
	localparam logic [16:0] RST_EULER_DT      = 17'd6554;
	localparam logic [16:0] RST_RECOVERY_RATE = 17'd1311;
	localparam logic [31:0] RST_RECOVERY_SENS = 32'd13107;
	localparam logic [31:0] RST_RESET_VOLTAGE = 32'hFFBF_0000;
	localparam logic [31:0] RST_RECOVERY_JUMP = 32'd524288;
	localparam logic [31:0] RST_BIAS_CURRENT  = 32'd0;
	localparam logic [31:0] RST_SPIKE_THRESH  = 32'd1966080;
	localparam logic [31:0] RST_VOLTAGE_FLOOR = 32'h8000_0000;

	// Register indexes (byte address divided by four).
	localparam logic [2:0] REG_EULER_DT        = 3'd0;
	localparam logic [2:0] REG_RECOVERY_RATE   = 3'd1;
	localparam logic [2:0] REG_RECOVERY_SENS   = 3'd2;
	localparam logic [2:0] REG_RESET_VOLTAGE   = 3'd3;
	localparam logic [2:0] REG_RECOVERY_JUMP   = 3'd4;
	localparam logic [2:0] REG_BIAS_CURRENT    = 3'd5;
	localparam logic [2:0] REG_SPIKE_THRESHOLD = 3'd6;
	localparam logic [2:0] REG_VOLTAGE_FLOOR   = 3'd7;

	// Datapath operation codes, one per multiplier pass.
	localparam logic [2:0] OP_NONE = 3'd0;
	localparam logic [2:0] OP_SQ   = 3'd1;
	localparam logic [2:0] OP_BV   = 3'd2;
	localparam logic [2:0] OP_AI   = 3'd3;
	localparam logic [2:0] OP_DV   = 3'd4;
	localparam logic [2:0] OP_DU   = 3'd5;

	typedef struct packed {
		logic [16:0] euler_dt;
		logic [16:0] recovery_rate;
		logic [31:0] recovery_sensitivity;
		logic [31:0] reset_voltage;
		logic [31:0] recovery_jump;
		logic [31:0] bias_current;
		logic [31:0] spike_threshold;
		logic [31:0] voltage_floor;
	} cfg_t;

	typedef struct packed {
		logic       load;
		logic [2:0] op;
		logic       finish;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

	typedef struct packed {
		logic        spike;
		logic [31:0] membrane_v;
		logic [31:0] recovery_u;
	} res_t;

	// Saturate a wide signed value to the signed 32-bit range.
	function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] x);
		logic signed [31:0] r;
		if (x > PROD_W'(64'sd2147483647)) begin
			r = 32'sh7FFF_FFFF;
		end else if (x < PROD_W'(-64'sd2147483648)) begin
			r = 32'sh8000_0000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage

>>> hw/rtl/izh_ifs.sv
// Request channel carrying one simulation tick.
interface izh_tick_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] syn_input;
	logic signed [31:0] ext_current;

	modport source (output valid, output syn_input, output ext_current, input ready);
	modport sink (input valid, input syn_input, input ext_current, output ready);
endinterface

// Result channel carrying the neuron state after one tick.
interface izh_result_if;
	logic               valid;
	logic               ready;
	logic               spike;
	logic signed [31:0] membrane_v;
	logic signed [31:0] recovery_u;

	modport source (output valid, output spike, output membrane_v, output recovery_u,
		input ready);
	modport sink (input valid, input spike, input membrane_v, input recovery_u,
		output ready);
endinterface

>>> hw/rtl/izh_regs.sv
module izh_regs
	import izh_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [2:0] idx;
	logic       wr_en;
	cfg_t       cfg_q;

	assign idx    = paddr[ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Register writes on the access cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.euler_dt             <= RST_EULER_DT;
			cfg_q.recovery_rate        <= RST_RECOVERY_RATE;
			cfg_q.recovery_sensitivity <= RST_RECOVERY_SENS;
			cfg_q.reset_voltage        <= RST_RESET_VOLTAGE;
			cfg_q.recovery_jump        <= RST_RECOVERY_JUMP;
			cfg_q.bias_current         <= RST_BIAS_CURRENT;
			cfg_q.spike_threshold      <= RST_SPIKE_THRESH;
			cfg_q.voltage_floor        <= RST_VOLTAGE_FLOOR;
		end else if (wr_en) begin
			unique case (idx)
				REG_EULER_DT:        cfg_q.euler_dt             <= pwdata[16:0];
				REG_RECOVERY_RATE:   cfg_q.recovery_rate        <= pwdata[16:0];
				REG_RECOVERY_SENS:   cfg_q.recovery_sensitivity <= pwdata;
				REG_RESET_VOLTAGE:   cfg_q.reset_voltage        <= pwdata;
				REG_RECOVERY_JUMP:   cfg_q.recovery_jump        <= pwdata;
				REG_BIAS_CURRENT:    cfg_q.bias_current         <= pwdata;
				REG_SPIKE_THRESHOLD: cfg_q.spike_threshold      <= pwdata;
				REG_VOLTAGE_FLOOR:   cfg_q.voltage_floor        <= pwdata;
				default: ;
			endcase
		end
	end

	// Read mux.
	always_comb begin
		unique case (idx)
			REG_EULER_DT:        prdata = 32'(cfg_q.euler_dt);
			REG_RECOVERY_RATE:   prdata = 32'(cfg_q.recovery_rate);
			REG_RECOVERY_SENS:   prdata = cfg_q.recovery_sensitivity;
			REG_RESET_VOLTAGE:   prdata = cfg_q.reset_voltage;
			REG_RECOVERY_JUMP:   prdata = cfg_q.recovery_jump;
			REG_BIAS_CURRENT:    prdata = cfg_q.bias_current;
			REG_SPIKE_THRESHOLD: prdata = cfg_q.spike_threshold;
			REG_VOLTAGE_FLOOR:   prdata = cfg_q.voltage_floor;
			default:             prdata = 32'd0;
		endcase
	end

endmodule

>>> hw/rtl/izh_ctrl.sv
module izh_ctrl
	import izh_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    tick_valid,
	output logic    tick_ready,
	input  status_t status,
	output cmd_t    cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SQ   = 3'd1;
	localparam logic [2:0] S_BV   = 3'd2;
	localparam logic [2:0] S_AI   = 3'd3;
	localparam logic [2:0] S_DV   = 3'd4;
	localparam logic [2:0] S_DU   = 3'd5;
	localparam logic [2:0] S_FIN  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign tick_ready = (state_q == S_IDLE);

	// Next state and datapath commands.
	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.op     = OP_NONE;
		cmd.finish = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (tick_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SQ;
				end
			end
			S_SQ: begin
				cmd.op  = OP_SQ;
				state_d = S_BV;
			end
			S_BV: begin
				cmd.op  = OP_BV;
				state_d = S_AI;
			end
			S_AI: begin
				cmd.op  = OP_AI;
				state_d = S_DV;
			end
			S_DV: begin
				cmd.op  = OP_DV;
				state_d = S_DU;
			end
			S_DU: begin
				cmd.op  = OP_DU;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (status.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> hw/rtl/izh_dp.sv
module izh_dp
	import izh_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  cmd_t               cmd,
	output status_t            status,
	input  logic signed [31:0] syn_input,
	input  logic signed [31:0] ext_current,
	output logic               res_valid,
	input  logic               res_ready,
	output res_t               res
);

	// Neuron state.
	logic signed [31:0] v_q;
	logic signed [31:0] u_q;
	logic signed [31:0] held_q;

	// Per-tick working registers.
	logic signed [31:0] drive_q;
	logic signed [47:0] sq_q;
	logic signed [43:0] quad_q;
	logic signed [31:0] deriv_q;
	logic signed [31:0] inner_q;
	logic signed [31:0] vn_q;
	logic signed [31:0] un_q;

	// Result register.
	logic               out_valid_q;
	res_t               res_q;

	logic signed [MUL_W-1:0]  ma;
	logic signed [MUL_W-1:0]  mb;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] prod_sh;
	logic signed [59:0]       quad_full;
	logic signed [47:0]       deriv_sum;
	logic signed [31:0]       vsat;
	logic signed [31:0]       vfloor;
	logic signed [31:0]       vthr;
	logic                     fired;
	logic signed [31:0]       v_next;
	logic signed [31:0]       u_next;

	assign status.out_free = !out_valid_q || res_ready;
	assign res_valid       = out_valid_q;
	assign res             = res_q;

	// Shared multiplier operand select.
	always_comb begin
		case (cmd.op)
			OP_SQ: begin
				ma = MUL_W'(v_q);
				mb = MUL_W'(v_q);
			end
			OP_BV: begin
				ma = MUL_W'($signed(cfg.recovery_sensitivity));
				mb = MUL_W'(v_q);
			end
			OP_AI: begin
				ma = $signed({16'd0, cfg.recovery_rate});
				mb = MUL_W'(inner_q);
			end
			OP_DV: begin
				ma = $signed({16'd0, cfg.euler_dt});
				mb = MUL_W'(deriv_q);
			end
			OP_DU: begin
				ma = $signed({16'd0, cfg.euler_dt});
				mb = MUL_W'(inner_q);
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign prod    = ma * mb;
	assign prod_sh = prod >>> Q_FRAC;

	// Quadratic term and voltage derivative, off the shared multiplier.
	assign quad_full = 60'(sq_q) * 60'(K_QUAD);
	assign deriv_sum = 48'(quad_q) + 48'(v_q) + (48'(v_q) <<< 2) + 48'(K_REST)
		- 48'(u_q) + 48'(drive_q);

	// Voltage update with lower clamp.
	assign vfloor = $signed(cfg.voltage_floor);
	assign vsat   = sat32(PROD_W'(v_q) + prod_sh);

	// Spike decision and reset.
	assign vthr   = $signed(cfg.spike_threshold);
	assign fired  = (vn_q >= vthr);
	assign v_next = fired ? $signed(cfg.reset_voltage) : vn_q;
	assign u_next = fired ? sat32(PROD_W'(un_q) + PROD_W'($signed(cfg.recovery_jump))) : un_q;

	// Neuron state, held current and result handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q         <= V_INIT;
			u_q         <= U_INIT;
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				held_q <= sat32(PROD_W'(ext_current) + PROD_W'($signed(cfg.bias_current)));
			end
			if (cmd.finish) begin
				v_q         <= v_next;
				u_q         <= u_next;
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers, one pass of the multiplier per step.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			drive_q <= sat32(PROD_W'(syn_input) + PROD_W'(held_q));
		end
		case (cmd.op)
			OP_SQ: sq_q <= prod_sh[47:0];
			OP_BV: begin
				inner_q <= sat32(PROD_W'(sat32(prod_sh)) - PROD_W'(u_q));
				quad_q  <= quad_full[59:16];
			end
			OP_AI: begin
				inner_q <= sat32(prod_sh);
				deriv_q <= sat32(PROD_W'(deriv_sum));
			end
			OP_DV: vn_q <= (vsat < vfloor) ? vfloor : vsat;
			OP_DU: un_q <= sat32(PROD_W'(u_q) + prod_sh);
			default: ;
		endcase
		if (cmd.finish) begin
			res_q.spike      <= fired;
			res_q.membrane_v <= v_next;
			res_q.recovery_u <= u_next;
		end
	end

endmodule

>>> hw/rtl/izhikevich_neuron_step_core.sv
// Izhikevich neuron, one forward-Euler step per simulation tick.
//
// Each request on the tick channel carries the synaptic input of this tick
// and an external current that drives the next tick. The result channel
// returns the spike flag, the new membrane voltage and the new recovery
// value, one result per request, all in signed Q16.16. Parameters are set
// through the APB port; the user must set them only while no tick is in
// flight, as the block itself does not enforce this.
//
// The step runs as five passes through one shared 33x33 multiplier (v*v,
// b*v, a*inner, dt*dv, dt*du) followed by a spike and reset step, and the
// result is registered at its end, so no new request is taken until the
// step has finished. The result waits in an output register; the block
// takes the next request while it waits, and stalls only in its spike and
// reset step if that result has not yet been taken.
// Reset sets v to -70, u to -14, the held current to zero and all parameter
// registers to their defaults, and leaves the result channel empty.
module izhikevich_neuron_step_core
	import izh_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	izh_tick_if.sink            tick,
	izh_result_if.source        result
);

	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;
	res_t    res;
	logic    res_valid;

	izh_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	izh_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (tick.valid),
		.tick_ready (tick.ready),
		.status     (status),
		.cmd        (cmd)
	);

	izh_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (cmd),
		.status      (status),
		.syn_input   (tick.syn_input),
		.ext_current (tick.ext_current),
		.res_valid   (res_valid),
		.res_ready   (result.ready),
		.res         (res)
	);

	assign result.valid      = res_valid;
	assign result.spike      = res.spike;
	assign result.membrane_v = res.membrane_v;
	assign result.recovery_u = res.recovery_u;

	// A taken request keeps the block busy on the following cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		tick.valid && tick.ready |=> !tick.ready)
		else $error("request accepted while a step was in flight");

	// A new result only appears at the end of a step, never from idle.
	a_result_from_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(!tick.ready))
		else $error("result raised without a step in progress");

	// A spiking result reports the reset voltage.
	a_spike_resets_v: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.spike |-> result.membrane_v == $signed(cfg.reset_voltage))
		else $error("spike without voltage reset");

	// A non-spiking result never lies below the voltage floor.
	a_floor_held: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.spike |-> result.membrane_v >= $signed(cfg.voltage_floor))
		else $error("membrane voltage below floor");

endmodule
